@@ design/zbsr_pkg.sv @@
// Shared types, constants and helpers for the z-buffered sphere point renderer.
// No dependencies; the other design files except zbsr_mem refer to this package by scoped names.
`default_nettype none
package zbsr_pkg;

  // Default geometry and angle resolution
  localparam int unsigned DEF_SCREEN_COLS = 80;
  localparam int unsigned DEF_SCREEN_ROWS = 40;
  localparam int unsigned DEF_ANGLE_BITS  = 12;

  // Widths of the shared datapath
  localparam int unsigned PROD_W  = 52;   // signed product / accumulator
  localparam int unsigned COORD_W = 18;   // Q4.14 coordinates and trig values
  localparam int unsigned DEN_W   = 18;   // depth denominator
  localparam int unsigned OOZ_W   = 16;   // inverse depth, unsigned Q0.16

  // Odd sine polynomial coefficients (Q16)
  localparam int unsigned SIN_C1 = 102944;
  localparam int unsigned SIN_C2 = 42047;
  localparam int unsigned SIN_C3 = 4639;
  localparam int unsigned ONE_Q14 = 16384;

  // Normalised light in Q14
  localparam int LIGHT_X = 6210;
  localparam int LIGHT_Y = 12421;
  localparam int LIGHT_Z = -8694;

  // Viewer distance 6.0 in Q14, minimum depth denominator
  localparam int unsigned VIEW_DIST_Q14 = 98304;
  localparam int unsigned DEN_MIN       = 16385;

  // Grid spacing in whole degrees
  localparam int unsigned GRID_POLAR_STEP  = 20;
  localparam int unsigned GRID_POLAR_LINES = 360 / GRID_POLAR_STEP;
  localparam int unsigned GRID_AZIM_STEP   = 30;
  localparam int unsigned GRID_AZIM_LINES  = 360 / GRID_AZIM_STEP;

  // Input modes
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PLOT  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ROT_X = 2'd0;
  localparam logic [1:0] REG_ROT_Y = 2'd1;
  localparam logic [1:0] REG_ROT_Z = 2'd2;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // Divider status
  typedef struct packed {
    logic             done;
    logic [OOZ_W-1:0] quo;
  } div_rsp_t;

  // Round a Q28 sum to Q14: floor((p + 8192) / 16384)
  function automatic logic signed [COORD_W-1:0] round_q14(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(8192);
    return t[COORD_W+13:14];
  endfunction

  // True when deg mod step is 0 or 1
  function automatic logic grid_hit(input logic [8:0] deg, input int unsigned step,
                                    input int unsigned lines);
    logic hit;
    hit = 1'b0;
    for (int unsigned k = 0; k < 18; k++) begin
      if (k < lines) begin
        if (deg == 9'(k * step) || deg == 9'(k * step + 1)) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

@@ design/zbsr_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on zbsr_pkg for the product width.
`default_nettype none
module zbsr_mul (
  input  wire logic                                clk,
  input  wire logic signed [31:0]                  a,
  input  wire logic signed [19:0]                  b,
  output logic signed [zbsr_pkg::PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    prod <= zbsr_pkg::PROD_W'(a * b);
  end

endmodule
`default_nettype wire

@@ design/zbsr_div.sv @@
// Restoring divider for inverse depth: 2^30 / den, one quotient bit a cycle.
// Depends on zbsr_pkg for the request and status structs.
`default_nettype none
module zbsr_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire zbsr_pkg::div_req_t req,
  output zbsr_pkg::div_rsp_t      rsp
);

  localparam int unsigned NUM_W = 31;

  logic [zbsr_pkg::DEN_W-1:0] den;
  logic [zbsr_pkg::DEN_W-1:0] rem;
  logic [NUM_W-1:0]           num;
  logic [NUM_W-1:0]           quo;
  logic [4:0]                 count;
  logic                       busy;
  logic                       done;
  logic [zbsr_pkg::DEN_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        den   <= req.den;
        rem   <= '0;
        num   <= NUM_W'(1) << 30;
        quo   <= '0;
        count <= '0;
      end else if (busy) begin
        rem   <= fits ? zbsr_pkg::DEN_W'(rem_sh - {1'b0, den}) : rem_sh[zbsr_pkg::DEN_W-1:0];
        num   <= {num[NUM_W-2:0], 1'b0};
        quo   <= {quo[NUM_W-2:0], fits};
        count <= count + 5'd1;
        if (count == 5'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo[zbsr_pkg::OOZ_W-1:0];

endmodule
`default_nettype wire

@@ design/zbsr_mem.sv @@
// Cell memory holding {inverse depth, shade} per screen cell.
// One write and one registered read port; depends on no other file.
`default_nettype none
module zbsr_mem #(
  parameter int unsigned DEPTH  = 3200,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 20
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ design/zbuffered_sphere_point_renderer.sv @@
// Z-buffered sphere point renderer: top level with sequencer, configuration and output register.
// Depends on zbsr_pkg, zbsr_mul, zbsr_div and zbsr_mem.
//
// One item is taken at a time. A plot item on a grid line is taken, then passes through evaluation
// of ten sine/cosine values, the three rotations, the bit-serial inverse depth divide (31 quotient
// bits and a hand-over), projection, shading and the depth test, and a load of the output
// register, all on one shared 32x20 multiplier.
// An off-grid plot or a no-operation item goes straight to the output register, a read passes
// through a registered memory read, and a clear zeroes the SCREEN_COLS x SCREEN_ROWS entries of
// the cell memory one entry a cycle. The same clearing pass runs straight after reset, during which
// no item is taken; configuration writes are taken at any time but must only be made while the
// block is idle.
// A finished result sits in an output register, so the next item is accepted while it waits.
`default_nettype none
module zbuffered_sphere_point_renderer #(
  parameter int unsigned SCREEN_COLS = zbsr_pkg::DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = zbsr_pkg::DEF_SCREEN_ROWS,
  parameter int unsigned ANGLE_BITS  = zbsr_pkg::DEF_ANGLE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // polar_angle[10:0], azimuth_angle[22:11], cell_index[34:23]
  input  wire logic [1:0]  s_axis_tuser,   // mode
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // shade_level[3:0], column[10:4], row[16:11]
  output logic             m_axis_tuser,   // written
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int unsigned CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned PW     = zbsr_pkg::PROD_W;
  localparam int unsigned CW     = zbsr_pkg::COORD_W;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [31:0] KX = 32'(44 * SCREEN_ROWS);
  localparam logic signed [31:0] KY = 32'(2 * SCREEN_ROWS);
  localparam logic signed [PW-1:0] CX_OFF = PW'(64'(SCREEN_COLS / 2) * 64'd10 * (64'd1 << 30));
  localparam logic signed [PW-1:0] CY_OFF = PW'(64'(SCREEN_ROWS / 2) * (64'd1 << 30));
  localparam logic signed [21:0] XLIM = 22'(10 * SCREEN_COLS);
  localparam logic signed [21:0] YLIM = 22'(SCREEN_ROWS);

  // Trig slots: sine/cosine of polar, azimuth, and the three rotations
  localparam int unsigned T_ST = 0;
  localparam int unsigned T_CT = 1;
  localparam int unsigned T_SP = 2;
  localparam int unsigned T_CP = 3;
  localparam int unsigned T_SX = 4;
  localparam int unsigned T_CX = 5;
  localparam int unsigned T_SY = 6;
  localparam int unsigned T_CY = 7;
  localparam int unsigned T_SZ = 8;
  localparam int unsigned T_CZ = 9;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ_WAIT, S_TRIG, S_ROT, S_DIV, S_PROJ, S_DONE
  } state_t;

  state_t state;

  // Masked angle to 16-bit phase
  function automatic logic [15:0] to_phase(input logic [15:0] a);
    logic [31:0] t;
    t = ({16'b0, a} & ANG_MASK) << (16 - ANGLE_BITS);
    return t[15:0];
  endfunction

  // Masked angle to whole degrees
  function automatic logic [8:0] to_deg(input logic [15:0] a);
    logic [31:0] t;
    t = (({16'b0, a} & ANG_MASK) * 32'd360) >> ANGLE_BITS;
    return t[8:0];
  endfunction

  function automatic logic signed [31:0] ext_a(input logic signed [CW-1:0] v);
    return signed'({{(32 - CW){v[CW-1]}}, v});
  endfunction

  function automatic logic signed [19:0] ext_b(input logic signed [CW-1:0] v);
    return signed'({{(20 - CW){v[CW-1]}}, v});
  endfunction

  // Configuration registers
  logic [11:0] rot_x, rot_y, rot_z;

  // Item registers
  logic [10:0] item_polar;
  logic [11:0] item_azim;
  logic [11:0] item_cell;
  logic        item_cell_ok;

  // Sequencer registers
  logic [4:0]  step;
  logic [3:0]  ti;
  logic [AW-1:0] clr_addr;
  logic        clr_item;
  logic [1:0]  tq;
  logic [16:0] tx, tx2;
  logic signed [CW-1:0] trig [10];
  logic signed [CW-1:0] x0, y0, y1, z1, x2, z2, x3, y3;
  logic signed [PW-1:0] acc, sxp, syp;
  logic [zbsr_pkg::OOZ_W-1:0] ooz;
  logic [30:0] kx;
  logic [25:0] ky;
  logic [7:0]  xp, yp;
  logic        inb;
  logic [3:0]  lvl;
  logic [AW-1:0] cell_addr;
  logic [3:0]  res_shade;
  logic        res_written;
  logic [6:0]  res_col;
  logic [5:0]  res_row;

  // Shared units
  logic signed [31:0]   mul_a;
  logic signed [19:0]   mul_b;
  logic signed [PW-1:0] prod;
  zbsr_pkg::div_req_t   div_req;
  zbsr_pkg::div_rsp_t   div_rsp;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [19:0]   mem_wr_data, mem_rd_data;

  // Input decode at transfer
  logic       s_fire;
  logic [1:0] in_mode;
  logic [10:0] in_polar;
  logic [11:0] in_azim, in_cell;
  logic       in_grid;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser;
  assign in_polar      = s_axis_tdata[10:0];
  assign in_azim       = s_axis_tdata[22:11];
  assign in_cell       = s_axis_tdata[34:23];
  assign in_grid = zbsr_pkg::grid_hit(to_deg({5'b0, in_polar}), zbsr_pkg::GRID_POLAR_STEP,
                                      zbsr_pkg::GRID_POLAR_LINES)
                || zbsr_pkg::grid_hit(to_deg({4'b0, in_azim}), zbsr_pkg::GRID_AZIM_STEP,
                                      zbsr_pkg::GRID_AZIM_LINES);

  // Sine evaluation datapath
  logic [15:0] base_ph, ph;
  logic [16:0] xf, x_new, inner_new, mid_new, s_val, v_sum;
  logic [14:0] v_mag;
  logic signed [CW-1:0] v_signed;

  always_comb begin
    unique case (ti[3:1])
      3'd0:    base_ph = to_phase({5'b0, item_polar});
      3'd1:    base_ph = to_phase({4'b0, item_azim});
      3'd2:    base_ph = to_phase({4'b0, rot_x});
      3'd3:    base_ph = to_phase({4'b0, rot_y});
      3'd4:    base_ph = to_phase({4'b0, rot_z});
      default: base_ph = '0;
    endcase
  end

  assign ph        = base_ph + (ti[0] ? 16'h4000 : 16'h0000);
  assign xf        = {1'b0, ph[13:0], 2'b00};
  assign x_new     = ph[14] ? 17'h10000 - xf : xf;
  assign inner_new = 17'(zbsr_pkg::SIN_C2) - {4'b0, prod[28:16]};
  assign mid_new   = 17'(zbsr_pkg::SIN_C1) - {1'b0, prod[31:16]};
  assign s_val     = prod[32:16];
  assign v_sum     = s_val + 17'd2;
  assign v_mag     = (v_sum[16:2] > 15'(zbsr_pkg::ONE_Q14)) ? 15'(zbsr_pkg::ONE_Q14) : v_sum[16:2];
  assign v_signed  = tq[1] ? -signed'({3'b0, v_mag}) : signed'({3'b0, v_mag});

  // Projection bounds and shade
  logic signed [21:0] hx, hy;
  logic               x_ok, y_ok;
  logic [7:0]         yp_c;
  logic signed [PW-1:0] lvl_prod, lvl_q;
  logic [3:0]         lvl_c;
  logic               hit;

  assign hx   = sxp[51:30];
  assign hy   = syp[51:30];
  assign x_ok = (hx > -22'sd10 || (hx == -22'sd10 && sxp[29:0] != '0)) && (hx < XLIM);
  assign y_ok = hy[21] ? (hy == -22'sd1 && syp[29:0] != '0) : (hy < YLIM);
  assign yp_c = hy[21] ? 8'd0 : hy[7:0];

  assign lvl_prod = acc + (acc <<< 3);
  assign lvl_q    = lvl_prod >>> 29;
  assign lvl_c    = acc[PW-1] ? 4'd0 : (lvl_q > PW'(9)) ? 4'd9 : lvl_q[3:0];
  assign hit      = inb && (ooz > mem_rd_data[19:4]);

  // Depth denominator, held at or above the minimum
  logic signed [CW:0] den_raw;
  assign den_raw = {z2[CW-1], z2} + (CW + 1)'(zbsr_pkg::VIEW_DIST_Q14);
  assign div_req.start = (state == S_ROT) && (step == 5'd16);
  assign div_req.den   = (den_raw < (CW + 1)'(zbsr_pkg::DEN_MIN)) ?
                         zbsr_pkg::DEN_W'(zbsr_pkg::DEN_MIN) : den_raw[zbsr_pkg::DEN_W-1:0];

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_TRIG: begin
        case (step)
          5'd0: begin mul_a = signed'({15'b0, x_new});     mul_b = signed'({3'b0, x_new}); end
          5'd1: begin mul_a = 32'(zbsr_pkg::SIN_C3);        mul_b = signed'({3'b0, s_val}); end
          5'd2: begin mul_a = signed'({15'b0, inner_new}); mul_b = signed'({3'b0, tx2}); end
          5'd3: begin mul_a = signed'({15'b0, mid_new});   mul_b = signed'({3'b0, tx}); end
          default: ;
        endcase
      end
      S_ROT: begin
        case (step)
          5'd0:  begin mul_a = ext_a(trig[T_ST]); mul_b = ext_b(trig[T_CP]); end
          5'd1:  begin mul_a = ext_a(trig[T_ST]); mul_b = ext_b(trig[T_SP]); end
          5'd3:  begin mul_a = ext_a(y0);         mul_b = ext_b(trig[T_CX]); end
          5'd4:  begin mul_a = ext_a(trig[T_CT]); mul_b = ext_b(trig[T_SX]); end
          5'd5:  begin mul_a = ext_a(y0);         mul_b = ext_b(trig[T_SX]); end
          5'd6:  begin mul_a = ext_a(trig[T_CT]); mul_b = ext_b(trig[T_CX]); end
          5'd8:  begin mul_a = ext_a(x0);         mul_b = ext_b(trig[T_CY]); end
          5'd9:  begin mul_a = ext_a(z1);         mul_b = ext_b(trig[T_SY]); end
          5'd10: begin mul_a = ext_a(x0);         mul_b = ext_b(trig[T_SY]); end
          5'd11: begin mul_a = ext_a(z1);         mul_b = ext_b(trig[T_CY]); end
          5'd12: begin mul_a = ext_a(x2);         mul_b = ext_b(trig[T_CZ]); end
          5'd13: begin mul_a = ext_a(y1);         mul_b = ext_b(trig[T_SZ]); end
          5'd14: begin mul_a = ext_a(x2);         mul_b = ext_b(trig[T_SZ]); end
          5'd15: begin mul_a = ext_a(y1);         mul_b = ext_b(trig[T_CZ]); end
          default: ;
        endcase
      end
      S_PROJ: begin
        case (step)
          5'd0: begin mul_a = KX; mul_b = signed'({4'b0, ooz}); end
          5'd1: begin mul_a = KY; mul_b = signed'({4'b0, ooz}); end
          5'd2: begin mul_a = signed'({1'b0, kx}); mul_b = ext_b(x3); end
          5'd3: begin mul_a = signed'({6'b0, ky}); mul_b = ext_b(y3); end
          5'd4: begin mul_a = 32'(zbsr_pkg::LIGHT_X); mul_b = ext_b(x3); end
          5'd5: begin mul_a = 32'(zbsr_pkg::LIGHT_Y); mul_b = ext_b(y3); end
          5'd6: begin mul_a = 32'(zbsr_pkg::LIGHT_Z); mul_b = ext_b(z2); end
          5'd7: begin mul_a = 32'd6554; mul_b = signed'({8'b0, hx[11:0]}); end
          5'd8: begin mul_a = 32'(SCREEN_COLS); mul_b = signed'({12'b0, yp_c}); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Cell memory control
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = cell_addr;
    if (state == S_CLEAR) begin
      mem_wr_en = 1'b1;
    end else if (state == S_PROJ && step == 5'd11 && hit) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = cell_addr;
      mem_wr_data = {ooz, lvl};
    end
    if (state == S_READ) begin
      mem_rd_en   = item_cell_ok;
      mem_rd_addr = AW'(item_cell);
    end else if (state == S_PROJ && step == 5'd10) begin
      mem_rd_en = inb;
    end
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_item      <= 1'b0;
      step          <= '0;
      ti            <= '0;
      m_axis_tvalid <= 1'b0;
      rot_x         <= '0;
      rot_y         <= '0;
      rot_z         <= '0;
    end else begin
      // drop the result once it is taken, unless a new one is loaded below
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          zbsr_pkg::REG_ROT_X: rot_x <= cfg_data;
          zbsr_pkg::REG_ROT_Y: rot_y <= cfg_data;
          zbsr_pkg::REG_ROT_Z: rot_z <= cfg_data;
          default: ;  // no register there: drop the write
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= (clr_addr == AW'(CELLS - 1)) ? '0 : clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= clr_item ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (s_fire) begin
            item_polar   <= in_polar;
            item_azim    <= in_azim;
            item_cell    <= in_cell;
            item_cell_ok <= {4'b0, in_cell} < 16'(CELLS);
            res_shade    <= '0;
            res_written  <= 1'b0;
            res_col      <= '0;
            res_row      <= '0;
            step         <= '0;
            ti           <= '0;
            unique case (in_mode)
              zbsr_pkg::MODE_CLEAR: begin
                clr_item <= 1'b1;
                state    <= S_CLEAR;
              end
              zbsr_pkg::MODE_PLOT: state <= in_grid ? S_TRIG : S_DONE;
              zbsr_pkg::MODE_READ: state <= S_READ;
              default:             state <= S_DONE;
            endcase
          end
        end

        S_READ: state <= S_READ_WAIT;

        S_READ_WAIT: begin
          res_shade <= item_cell_ok ? mem_rd_data[3:0] : 4'd0;
          state     <= S_DONE;
        end

        S_TRIG: begin
          step <= (step == 5'd4) ? 5'd0 : step + 5'd1;
          case (step)
            5'd0: begin
              tq <= ph[15:14];
              tx <= x_new;
            end
            5'd1: tx2 <= s_val;
            5'd4: begin
              trig[ti] <= v_signed;
              ti       <= ti + 4'd1;
              if (ti == 4'(T_CZ)) state <= S_ROT;
            end
            default: ;
          endcase
        end

        S_ROT: begin
          step <= (step == 5'd16) ? 5'd0 : step + 5'd1;
          case (step)
            5'd1:  x0  <= zbsr_pkg::round_q14(prod);
            5'd2:  y0  <= zbsr_pkg::round_q14(prod);
            5'd4:  acc <= prod;
            5'd5:  y1  <= zbsr_pkg::round_q14(acc - prod);
            5'd6:  acc <= prod;
            5'd7:  z1  <= zbsr_pkg::round_q14(acc + prod);
            5'd9:  acc <= prod;
            5'd10: x2  <= zbsr_pkg::round_q14(acc + prod);
            5'd11: acc <= -prod;
            5'd12: z2  <= zbsr_pkg::round_q14(acc + prod);
            5'd13: acc <= prod;
            5'd14: x3  <= zbsr_pkg::round_q14(acc - prod);
            5'd15: acc <= prod;
            5'd16: begin
              y3    <= zbsr_pkg::round_q14(acc + prod);
              state <= S_DIV;
            end
            default: ;
          endcase
        end

        S_DIV: begin
          if (div_rsp.done) begin
            ooz   <= div_rsp.quo;
            state <= S_PROJ;
          end
        end

        S_PROJ: begin
          step <= (step == 5'd11) ? 5'd0 : step + 5'd1;
          case (step)
            5'd1: kx  <= prod[30:0];
            5'd2: ky  <= prod[25:0];
            5'd3: sxp <= CX_OFF + prod;
            5'd4: syp <= CY_OFF - prod;
            5'd5: acc <= prod;
            5'd6: acc <= acc + prod;
            5'd7: acc <= acc + prod + (PW'(1) <<< 28);
            5'd8: begin
              // negative but above minus one: truncation lands on zero
              xp  <= hx[21] ? 8'd0 : prod[23:16];
              yp  <= yp_c;
              inb <= x_ok && y_ok;
              lvl <= lvl_c;
            end
            5'd9: cell_addr <= prod[AW-1:0] + AW'(xp);
            5'd11: begin
              if (hit) begin
                res_shade   <= lvl;
                res_written <= 1'b1;
                res_col     <= xp[6:0];
                res_row     <= yp[5:0];
              end
              state <= S_DONE;
            end
            default: ;
          endcase
        end

        S_DONE: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, res_row, res_col, res_shade};
            m_axis_tuser  <= res_written;
            clr_item      <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  zbsr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  zbsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  zbsr_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (AW),
    .DATA_W (20)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Writes stay inside the screen
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> ({1'b0, mem_wr_addr} < (AW + 1)'(CELLS)))
    else $error("cell write beyond the last cell");

  // A result that was not plotted carries no cell position
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[16:4] == '0))
    else $error("unwritten result with non-zero cell");

  // Divider answers only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside its wait");

  // An accepted item keeps the input side closed in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_axis_tready)
    else $error("input taken twice in a row");

endmodule
`default_nettype wire

@@ sim/zbsr_checker.sv @@
// Scoreboard for the z-buffered sphere point renderer: watches the input, result and
// configuration channels, predicts each result and compares it. Depends on zbsr_pkg.
`timescale 1ns / 100ps
module zbsr_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,
  input  wire logic        m_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  import zbsr_pkg::*;

  localparam int COLS  = DEF_SCREEN_COLS;
  localparam int ROWS  = DEF_SCREEN_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [3:0] shade;
    logic       written;
    logic [6:0] column;
    logic [5:0] row;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [3:0]  shade_mem[CELLS];
  logic [15:0] depth_mem[CELLS];
  logic [11:0] rot_x, rot_y, rot_z;

  function automatic longint sine_q14(input logic [15:0] ph);
    longint unsigned x, x2, inner, mid, s, v;
    x = {ph[13:0], 2'b00};
    if (ph[14]) x = 65536 - x;
    x2 = (x * x) >> 16;
    inner = 42047 - ((4639 * x2) >> 16);
    mid = 102944 - ((inner * x2) >> 16);
    s = (mid * x) >> 16;
    v = (s + 2) >> 2;
    if (v > 16384) v = 16384;
    return ph[15] ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint cosine_q14(input logic [15:0] ph);
    return sine_q14(ph + 16'd16384);
  endfunction

  // Round a Q28 sum to Q14, flooring
  function automatic longint to_q14(input longint p);
    return (p + 8192) >>> 14;
  endfunction

  // Plot one sample into the shadow stores and return the pixel it produces
  function automatic pixel_t plot_sample(input logic [10:0] polar, input logic [11:0] azim);
    pixel_t r;
    int unsigned pd, ad, idx;
    longint st, ct, sp, cp, sx, cx, sy, cy, sz, cz;
    longint x0, y0, z0, y1, z1, x2, z2, x3, y3, d, ooz, xp, yp, b, lvl;
    r = '0;
    pd = (32'(polar) * 360) >> 12;
    ad = (32'(azim) * 360) >> 12;
    if (!((pd % 20) < 2 || (ad % 30) < 2)) return r;
    st = sine_q14({polar, 4'b0}); ct = cosine_q14({polar, 4'b0});
    sp = sine_q14({azim, 4'b0});  cp = cosine_q14({azim, 4'b0});
    sx = sine_q14({rot_x, 4'b0}); cx = cosine_q14({rot_x, 4'b0});
    sy = sine_q14({rot_y, 4'b0}); cy = cosine_q14({rot_y, 4'b0});
    sz = sine_q14({rot_z, 4'b0}); cz = cosine_q14({rot_z, 4'b0});
    x0 = to_q14(st * cp);
    y0 = to_q14(st * sp);
    z0 = ct;
    y1 = to_q14(y0 * cx - z0 * sx);
    z1 = to_q14(y0 * sx + z0 * cx);
    x2 = to_q14(x0 * cy + z1 * sy);
    z2 = to_q14(-x0 * sy + z1 * cy);
    x3 = to_q14(x2 * cz - y1 * sz);
    y3 = to_q14(x2 * sz + y1 * cz);
    d = z2 + 6 * 16384;
    if (d < 16385) d = 16385;
    ooz = ONE_Q30 / d;
    // signed division truncates toward zero, as the projection needs
    xp = (longint'(COLS / 2) * 10 * ONE_Q30 + 44 * ROWS * ooz * x3) / (10 * ONE_Q30);
    yp = (longint'(ROWS / 2) * ONE_Q30 - 2 * ROWS * ooz * y3) / ONE_Q30;
    if (xp < 0 || xp >= COLS || yp < 0 || yp >= ROWS) return r;
    idx = int'(yp * COLS + xp);
    if (ooz <= longint'(depth_mem[idx])) return r;
    b = x3 * LIGHT_X + y3 * LIGHT_Y + z2 * LIGHT_Z;
    lvl = ((b + 64'sd268435456) * 9) / 64'sd536870912;
    if (lvl < 0) lvl = 0;
    if (lvl > 9) lvl = 9;
    depth_mem[idx] = ooz[15:0];
    shade_mem[idx] = lvl[3:0];
    r.shade = lvl[3:0];
    r.written = 1'b1;
    r.column = xp[6:0];
    r.row = yp[5:0];
    return r;
  endfunction

  function automatic pixel_t predict_pixel(input mode_t mode, input logic [39:0] data);
    pixel_t r;
    r = '0;
    case (mode)
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shade_mem[i] = '0;
          depth_mem[i] = '0;
        end
      end
      MODE_PLOT: r = plot_sample(data[10:0], data[22:11]);
      MODE_READ: if (data[34:23] < CELLS) r.shade = shade_mem[data[34:23]];
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t want, got;
    if (rst) begin
      pixel_q.delete();
      for (int i = 0; i < CELLS; i++) begin
        shade_mem[i] = '0;
        depth_mem[i] = '0;
      end
      rot_x = '0; rot_y = '0; rot_z = '0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_X: rot_x = cfg_data;
          REG_ROT_Y: rot_y = cfg_data;
          REG_ROT_Z: rot_z = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[3:0], m_tuser, m_tdata[10:4], m_tdata[16:11]};
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result shade=%0d written=%0b col=%0d row=%0d",
                   $time, got.shade, got.written, got.column, got.row);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected shade=%0d written=%0b col=%0d row=%0d",
                     $time, want.shade, want.written, want.column, want.row);
            $display("%0t:          actual   shade=%0d written=%0b col=%0d row=%0d",
                     $time, got.shade, got.written, got.column, got.row);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) pixel_q.push_back(predict_pixel(mode_t'(s_tuser), s_tdata));
      pending <= pixel_q.size();
    end
  end

endmodule

@@ sim/tb_zbuffered_sphere_point_renderer.sv @@
// Testbench top for the z-buffered sphere point renderer: drives samples, reads, clears and
// rotation settings, and gives the verdict. Depends on zbsr_pkg, zbsr_checker and the renderer.
`timescale 1ns / 100ps
module tb_zbuffered_sphere_point_renderer;
  import zbsr_pkg::*;

  localparam int IDLE_LIMIT = 20000;   // longer than the reset clear pass or a clear item
  localparam int HOLD_CYCLES = 500;
  localparam int CELLS = DEF_SCREEN_COLS * DEF_SCREEN_ROWS;
  localparam logic [1:0] REG_SPARE = 2'd3;   // index past the last register, ignored

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;     // polar_angle[10:0], azimuth_angle[22:11], cell_index[34:23]
  logic [1:0]  s_axis_tuser = '0;     // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // shade_level[3:0], column[10:4], row[16:11]
  logic        m_axis_tuser;          // written
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int fail_count, pending;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int lit_cells[$];                   // cells reported as written, targets for reads

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  zbuffered_sphere_point_renderer dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  zbsr_checker scoreboard (
    .clk, .rst,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // Remember written cells so that reads hit something other than blank
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tuser)
      lit_cells.push_back(int'(m_axis_tdata[16:11]) * DEF_SCREEN_COLS + int'(m_axis_tdata[10:4]));
    if (lit_cells.size() > 64) void'(lit_cells.pop_front());
  end

  // Result side: random stalls, plus one long hold-off so the block backs up its input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= 800) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= !(rx_idle && $urandom_range(99) < 20);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit on_grid(input int unsigned angle, input int unsigned step);
    return ((((angle * 360) >> 12) % step) < 2);
  endfunction

  // Offer one item; leave tvalid high so a following item goes out back to back
  task automatic send_item(input mode_t mode, input logic [10:0] polar,
                           input logic [11:0] azim, input logic [11:0] cell_idx);
    while (tx_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {5'b0, cell_idx, azim, polar};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all results, let the block settle, then load a rotation
  task automatic set_rotation(input logic [11:0] ax, input logic [11:0] ay, input logic [11:0] az);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    write_reg(REG_ROT_X, ax);
    write_reg(REG_ROT_Y, ay);
    write_reg(REG_ROT_Z, az);
    write_reg(REG_SPARE, 12'($urandom_range(4095)));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly samples on grid lines so that most reach projection and the depth test
  task automatic send_random;
    int unsigned pick, polar, azim;
    pick = $urandom_range(99);
    polar = $urandom_range(2047);
    azim = $urandom_range(4095);
    if (pick < 70) begin
      if ($urandom_range(1)) while (!on_grid(polar, 20)) polar = $urandom_range(2047);
      else while (!on_grid(azim, 30)) azim = $urandom_range(4095);
      send_item(MODE_PLOT, 11'(polar), 12'(azim), 12'($urandom_range(4095)));
    end else if (pick < 80) begin
      send_item(MODE_PLOT, 11'(polar), 12'(azim), 12'($urandom_range(4095)));
    end else if (pick < 94) begin
      if (lit_cells.size() > 0 && $urandom_range(1))
        send_item(MODE_READ, 11'(polar), 12'(azim),
                  12'(lit_cells[$urandom_range(lit_cells.size() - 1)]));
      else
        send_item(MODE_READ, 11'(polar), 12'(azim), 12'($urandom_range(4095)));
    end else if (pick < 98) begin
      send_item(MODE_NOP, 11'(polar), 12'(azim), 12'($urandom_range(4095)));
    end else begin
      send_item(MODE_CLEAR, 11'(polar), 12'(azim), 12'($urandom_range(4095)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset rotation of zero
    send_item(MODE_PLOT, 11'd0, 12'd0, 12'd0);          // pole, on both grids
    send_item(MODE_PLOT, 11'd0, 12'd0, 12'd0);          // same cell again: not nearer
    send_item(MODE_PLOT, 11'd1024, 12'd0, 12'd0);       // equator
    send_item(MODE_PLOT, 11'd2047, 12'd0, 12'd0);       // polar extreme, azimuth grid
    send_item(MODE_PLOT, 11'd2047, 12'd4095, 12'd0);    // off both grids
    send_item(MODE_PLOT, 11'd12, 12'd4095, 12'd4095);   // on the polar grid, wide fields
    send_item(MODE_PLOT, 11'd500, 12'd1024, 12'd0);
    send_item(MODE_PLOT, 11'd227, 12'd3072, 12'd0);
    send_item(MODE_READ, 11'd0, 12'd0, 12'd0);
    send_item(MODE_READ, 11'd0, 12'd0, 12'(CELLS - 1));
    send_item(MODE_READ, 11'd0, 12'd0, 12'(CELLS));     // past the last cell
    send_item(MODE_READ, 11'h7FF, 12'hFFF, 12'hFFF);
    send_item(MODE_NOP, 11'h7FF, 12'hFFF, 12'hFFF);
    send_item(MODE_CLEAR, 11'd0, 12'd0, 12'd0);
    for (int i = 0; i < lit_cells.size() && i < 4; i++)
      send_item(MODE_READ, 11'd0, 12'd0, 12'(lit_cells[i])); // must read blank after the clear

    // Random phases, each under its own rotation; the extremes come first
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_rotation(12'd0, 12'd0, 12'd0);
        1: set_rotation(12'd4095, 12'd4095, 12'd4095);
        2: set_rotation(12'd1024, 12'd2048, 12'd3072);
        default: set_rotation(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                              12'($urandom_range(4095)));
      endcase
      if (phase > 0) send_item(MODE_CLEAR, 11'd0, 12'd0, 12'd0);
      for (int n = 0; n < 230; n++) begin
        // hold both sides steady through part of the run
        tx_idle = !(phase == 2);
        rx_idle = !(phase == 2);
        send_random();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
